>>> design/assert_macros.svh
// assertion macros for the design files
// no dependencies; included by files that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// next-cycle implication, off during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

>>> design/bba_pkg.sv
// shared constants and helpers of the buddy block allocator
// no dependencies; imported by buddy_block_allocator_top and tb_top
package bba_pkg;

   // default geometry
   localparam int HEAP_BYTES_DEF = 65536;
   localparam int UNIT_BYTES_DEF = 64;

   // field widths
   localparam int OP_W   = 2;
   localparam int SIZE_W = 17;
   localparam int OFF_W  = 16;
   localparam int STAT_W = 2;

   // operation codes
   localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
   localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
   localparam logic [OP_W-1:0] OP_REALLOC = 2'd2;
   localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOSPACE  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd2;

   // node states
   localparam logic [1:0] ND_EMPTY = 2'd0;
   localparam logic [1:0] ND_SPLIT = 2'd1;
   localparam logic [1:0] ND_FULL  = 2'd2;
   localparam logic [1:0] ND_ALLOC = 2'd3;

   // depth of the leaf level: halving stops once half a node is at most one unit
   function automatic int leaf_depth(input int heap, input int unit);
      int d;
      d = 0;
      while (d < 30 && (heap >> (d + 1)) > unit) d++;
      return d;
   endfunction

endpackage

>>> design/buddy_block_allocator_top.sv
// Buddy block allocator: state machine around one node-state memory.
// Allocate reads nodes down from the root, backtracks from a failed node to its right sibling
// or parent, then updates the levels above the taken node; free walks down by offset, then
// left to the allocated node, with the same update; reallocate does a free, then an allocate.
// Requests are handled one at a time; the next is taken only once the previous result is loaded.
// Reset clears every node in one pass, with requests stalled.
`include "assert_macros.svh"

module buddy_block_allocator_top #(
   parameter int HEAP_BYTES = bba_pkg::HEAP_BYTES_DEF,
   parameter int UNIT_BYTES = bba_pkg::UNIT_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [bba_pkg::OP_W-1:0]      req_operation,
   input  logic [bba_pkg::SIZE_W-1:0]    req_request_size,
   input  logic [bba_pkg::OFF_W-1:0]     req_block_offset,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [bba_pkg::STAT_W-1:0]    rsp_status,
   output logic [bba_pkg::OFF_W-1:0]     rsp_result_offset
);
   import bba_pkg::*;

   localparam int LEAF_D = leaf_depth(HEAP_BYTES, UNIT_BYTES);
   localparam int TREE_NODES = (2 << LEAF_D) - 1;
   localparam int SLOTS = 2 * HEAP_BYTES / UNIT_BYTES + 1;
   localparam int NODES = (TREE_NODES < SLOTS) ? TREE_NODES : SLOTS;
   localparam int NW = $clog2(NODES + 1);
   localparam int OW0 = $clog2(HEAP_BYTES) + 1;
   localparam int OW = (OW0 > SIZE_W) ? OW0 : SIZE_W;

   typedef enum logic [3:0] {
      CLEAR, IDLE, A_START, S_READ, S_CHK, S_FAIL,
      F_WALK, F_READ, F_CHK, P_WR, P_EVAL, DONE
   } fsm_type;

   fsm_type state_ff, state_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [SIZE_W-1:0] size_ff, size_in;
   logic [OFF_W-1:0]  boff_ff, boff_in;
   logic [NW-1:0]     idx_ff, idx_in;
   logic [NW-1:0]     clr_ff, clr_in;
   logic [OW-1:0]     cur_ff, cur_in;
   logic [OW-1:0]     off_ff, off_in;
   logic [OW-1:0]     probe_ff, probe_in;
   logic [OW-1:0]     jump_ff, jump_in;
   logic [1:0]        ps_ff, ps_in;
   logic              freed_ff, freed_in;
   logic              aph_ff, aph_in;
   logic [STAT_W-1:0] stat_ff, stat_in;
   logic [OFF_W-1:0]  roff_ff, roff_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [OFF_W-1:0]  rsp_offset_ff, rsp_offset_in;

   // node-state memory, two read ports, one write port
   logic [1:0]    node_mem [NODES];
   logic [1:0]    rd0_ff, rd1_ff;
   logic          mem_we;
   logic [NW-1:0] mem_waddr, ra0, ra1;
   logic [1:0]    mem_wdata;

   logic [NW+1:0] lchild_w, rchild_w;
   logic [NW-1:0] parent, brother;
   logic [OW-1:0] half, off_ext;
   logic          free_end, free_ok, prop_end, has_ns;
   logic [1:0]    ns;

   // tree neighbors of the current node
   assign lchild_w = ({2'b00, idx_ff} << 1) + (NW+2)'(1);
   assign rchild_w = lchild_w + (NW+2)'(1);
   assign parent   = (idx_ff - NW'(1)) >> 1;
   assign brother  = idx_ff[0] ? idx_ff + NW'(1) : idx_ff - NW'(1);
   assign half     = cur_ff >> 1;
   assign off_ext  = OW'(boff_ff);

   // next state of the sequencer
   always_comb begin
      state_in = state_ff;
      op_in = op_ff;
      size_in = size_ff;
      boff_in = boff_ff;
      idx_in = idx_ff;
      clr_in = clr_ff;
      cur_in = cur_ff;
      off_in = off_ff;
      probe_in = probe_ff;
      jump_in = jump_ff;
      ps_in = ps_ff;
      freed_in = freed_ff;
      aph_in = aph_ff;
      stat_in = stat_ff;
      roff_in = roff_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      mem_we = 1'b0;
      mem_waddr = idx_ff;
      mem_wdata = ps_ff;
      ra0 = idx_ff;
      ra1 = brother;
      free_end = 1'b0;
      free_ok = 1'b0;
      prop_end = 1'b0;
      has_ns = 1'b0;
      ns = ND_EMPTY;
      case (state_ff)
         CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = ND_EMPTY;
            clr_in = clr_ff + NW'(1);
            if (clr_ff == NW'(NODES - 1)) state_in = IDLE;
         end
         IDLE: begin
            if (req_valid) begin
               op_in = req_operation;
               size_in = req_request_size;
               boff_in = req_block_offset;
               freed_in = 1'b0;
               aph_in = 1'b0;
               idx_in = '0;
               probe_in = '0;
               jump_in = OW'(HEAP_BYTES) >> 1;
               case (req_operation)
                  OP_ALLOC: state_in = A_START;
                  OP_FREE, OP_REALLOC: state_in = F_WALK;
                  default: begin
                     stat_in = STAT_OK;
                     roff_in = '0;
                     state_in = DONE;
                  end
               endcase
            end
         end
         A_START: begin
            aph_in = 1'b1;
            if (OW'(size_ff) > OW'(HEAP_BYTES)) begin
               stat_in = STAT_NOSPACE;
               roff_in = '0;
               state_in = DONE;
            end else begin
               idx_in = '0;
               cur_in = OW'(HEAP_BYTES);
               off_in = '0;
               state_in = S_READ;
            end
         end
         S_READ: begin
            ra0 = idx_ff;
            state_in = S_CHK;
         end
         // take the node, fail, or descend to the left child
         S_CHK: begin
            if (OW'(size_ff) > half || half <= OW'(UNIT_BYTES)) begin
               if (rd0_ff == ND_EMPTY) begin
                  ps_in = ND_ALLOC;
                  state_in = P_WR;
               end else begin
                  state_in = S_FAIL;
               end
            end else if (rd0_ff == ND_FULL || rd0_ff == ND_ALLOC) begin
               state_in = S_FAIL;
            end else begin
               idx_in = lchild_w[NW-1:0];
               cur_in = half;
               state_in = S_READ;
            end
         end
         // backtrack: right sibling, else climb to the parent; at the root, no space
         S_FAIL: begin
            if (idx_ff == '0) begin
               stat_in = STAT_NOSPACE;
               roff_in = '0;
               state_in = DONE;
            end else if (idx_ff[0]) begin
               idx_in = idx_ff + NW'(1);
               off_in = off_ff + cur_ff;
               state_in = S_READ;
            end else begin
               idx_in = parent;
               off_in = off_ff - cur_ff;
               cur_in = cur_ff << 1;
            end
         end
         // descend by offset, one level a cycle
         F_WALK: begin
            if (probe_ff < off_ext) begin
               if (jump_ff == '0) begin
                  free_end = 1'b1;
               end else begin
                  jump_in = jump_ff >> 1;
                  if (probe_ff + jump_ff <= off_ext) begin
                     probe_in = probe_ff + jump_ff;
                     if (rchild_w >= (NW+2)'(NODES)) free_end = 1'b1;
                     else idx_in = rchild_w[NW-1:0];
                  end else begin
                     if (lchild_w >= (NW+2)'(NODES)) free_end = 1'b1;
                     else idx_in = lchild_w[NW-1:0];
                  end
               end
            end else begin
               state_in = F_READ;
            end
         end
         F_READ: begin
            ra0 = idx_ff;
            state_in = F_CHK;
         end
         // left walk until an allocated node
         F_CHK: begin
            if (rd0_ff == ND_ALLOC) begin
               ps_in = ND_EMPTY;
               state_in = P_WR;
            end else if (lchild_w >= (NW+2)'(NODES)) begin
               free_end = 1'b1;
            end else begin
               idx_in = lchild_w[NW-1:0];
               state_in = F_READ;
            end
         end
         // write the node, fetch parent and buddy
         P_WR: begin
            mem_we = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = ps_ff;
            ra0 = parent;
            ra1 = brother;
            if (idx_ff == '0) prop_end = 1'b1;
            else state_in = P_EVAL;
         end
         // decide the parent's new state
         P_EVAL: begin
            if (ps_ff == ND_EMPTY) begin
               if (rd0_ff == ND_FULL) begin
                  has_ns = 1'b1;
                  ns = ND_SPLIT;
               end else if (rd0_ff == ND_SPLIT && rd1_ff == ND_EMPTY) begin
                  has_ns = 1'b1;
                  ns = ND_EMPTY;
               end
            end else if (ps_ff == ND_SPLIT) begin
               if (rd0_ff != ND_SPLIT) begin
                  has_ns = 1'b1;
                  ns = ND_SPLIT;
               end
            end else begin
               if (rd0_ff == ND_EMPTY) begin
                  has_ns = 1'b1;
                  ns = ND_SPLIT;
               end else if (rd0_ff == ND_SPLIT && (rd1_ff == ND_FULL || rd1_ff == ND_ALLOC)) begin
                  has_ns = 1'b1;
                  ns = ND_FULL;
               end
            end
            if (has_ns) begin
               idx_in = parent;
               ps_in = ns;
               state_in = P_WR;
            end else begin
               prop_end = 1'b1;
            end
         end
         DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = stat_ff;
               rsp_offset_in = roff_ff;
               state_in = IDLE;
            end
         end
         default: state_in = IDLE;
      endcase

      // end of an update cascade
      if (prop_end) begin
         if (aph_ff) begin
            stat_in = (op_ff == OP_REALLOC && !freed_ff) ? STAT_NOTFOUND : STAT_OK;
            roff_in = off_ff[OFF_W-1:0];
            state_in = DONE;
         end else begin
            free_end = 1'b1;
            free_ok = 1'b1;
         end
      end

      // end of the free part
      if (free_end) begin
         freed_in = free_ok;
         if (op_ff == OP_FREE) begin
            stat_in = free_ok ? STAT_OK : STAT_NOTFOUND;
            roff_in = '0;
            state_in = DONE;
         end else begin
            state_in = A_START;
         end
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CLEAR;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff <= op_in;
      size_ff <= size_in;
      boff_ff <= boff_in;
      idx_ff <= idx_in;
      cur_ff <= cur_in;
      off_ff <= off_in;
      probe_ff <= probe_in;
      jump_ff <= jump_in;
      ps_ff <= ps_in;
      freed_ff <= freed_in;
      aph_ff <= aph_in;
      stat_ff <= stat_in;
      roff_ff <= roff_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   // node memory: outside the clear pass, writes never hit an address read in the same cycle
   always_ff @(posedge clock) begin
      if (mem_we) node_mem[mem_waddr] <= mem_wdata;
      rd0_ff <= node_mem[ra0];
      rd1_ff <= node_mem[ra1];
   end

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_result_offset = rsp_offset_ff;

   // checks
   `ASSERT_IMPL(a_root_size, clock, reset, state_ff == S_FAIL && idx_ff == '0, cur_ff == OW'(HEAP_BYTES))
   `ASSERT_IMPL(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == DONE)
   `ASSERT_IMPL(a_eval_not_root, clock, reset, state_ff == P_EVAL, idx_ff != '0)

endmodule

>>> dv/tb_top.sv
// testbench for buddy_block_allocator_top: random and directed alloc/free/realloc traffic
// depends on bba_pkg and the allocator RTL; holds its own node-state tree to predict grants
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import bba_pkg::*;

   localparam int HEAP  = HEAP_BYTES_DEF;
   localparam int UNIT  = UNIT_BYTES_DEF;
   localparam int NODES = HEAP / UNIT - 1;

   // tracks the node-state tree and the grants still owed by the block
   class heap_tracker;
      logic [1:0] tree[NODES];
      int found_off;
      int errors;
      int n_grant, n_freed, n_miss, n_full;
      logic [STAT_W-1:0] want_stat[$];
      logic [OFF_W-1:0]  want_off[$];

      function new();
         foreach (tree[i]) tree[i] = ND_EMPTY;
         errors = 0;
         n_grant = 0;
         n_freed = 0;
         n_miss = 0;
         n_full = 0;
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      // write a node and carry split/full/empty changes up the ancestors
      function void set_node(int i, logic [1:0] s);
         int p, b;
         logic [1:0] ps, bs;
         bit go;
         forever begin
            tree[i] = s;
            if (i == 0) return;
            p = (i - 1) >> 1;
            b = (i & 1) ? i + 1 : i - 1;
            ps = tree[p];
            bs = tree[b];
            go = 0;
            if (s == ND_EMPTY) begin
               if (ps == ND_FULL) begin
                  go = 1; s = ND_SPLIT;
               end else if (ps == ND_SPLIT && bs == ND_EMPTY) begin
                  go = 1; s = ND_EMPTY;
               end
            end else if (s == ND_SPLIT) begin
               if (ps != ND_SPLIT) begin
                  go = 1; s = ND_SPLIT;
               end
            end else begin
               if (ps == ND_EMPTY) begin
                  go = 1; s = ND_SPLIT;
               end else if (ps == ND_SPLIT && (bs == ND_FULL || bs == ND_ALLOC)) begin
                  go = 1; s = ND_FULL;
               end
            end
            if (!go) return;
            i = p;
         end
      endfunction

      // left-first depth-first search for the smallest empty node that fits
      function bit find_block(int size, int idx, int cur, int off);
         int half;
         half = cur >> 1;
         if (idx >= NODES || size > cur) return 0;
         if (size > half || half <= UNIT) begin
            if (tree[idx] != ND_EMPTY) return 0;
            set_node(idx, ND_ALLOC);
            found_off = off;
            return 1;
         end
         if (tree[idx] == ND_FULL || tree[idx] == ND_ALLOC) return 0;
         if (find_block(size, 2 * idx + 1, half, off)) return 1;
         return find_block(size, 2 * idx + 2, half, off + half);
      endfunction

      function bit grab(int size);
         if (size > HEAP) return 0;
         return find_block(size, 0, HEAP, 0);
      endfunction

      // walk down by offset, then left until an allocated node
      function bit release_at(int off);
         int node, probe, jump;
         node = 0;
         probe = 0;
         jump = HEAP >> 1;
         while (probe < off) begin
            if (jump == 0) return 0;
            if (probe + jump <= off) begin
               probe += jump;
               node = 2 * node + 2;
            end else begin
               node = 2 * node + 1;
            end
            jump >>= 1;
            if (node >= NODES) return 0;
         end
         while (tree[node] != ND_ALLOC) begin
            node = 2 * node + 1;
            if (node >= NODES) return 0;
         end
         set_node(node, ND_EMPTY);
         return 1;
      endfunction

      // accepted request: update the tree and queue the owed result
      function void note_request(logic [OP_W-1:0] op, int size, int off,
                                 output logic [STAT_W-1:0] st, output int got);
         bit freed;
         st = STAT_OK;
         got = 0;
         if (op == OP_ALLOC) begin
            if (grab(size)) got = found_off;
            else st = STAT_NOSPACE;
         end else if (op == OP_FREE) begin
            if (!release_at(off)) st = STAT_NOTFOUND;
         end else if (op == OP_REALLOC) begin
            freed = release_at(off);
            if (grab(size)) begin
               got = found_off;
               st = freed ? STAT_OK : STAT_NOTFOUND;
            end else begin
               st = STAT_NOSPACE;
            end
         end
         if (st == STAT_NOSPACE) n_full++;
         else if (st == STAT_NOTFOUND) n_miss++;
         if (op == OP_ALLOC && st == STAT_OK) n_grant++;
         if (op == OP_FREE && st == STAT_OK) n_freed++;
         want_stat.push_back(st);
         want_off.push_back(got[OFF_W-1:0]);
      endfunction

      task check_result(logic [STAT_W-1:0] st, logic [OFF_W-1:0] off);
         logic [STAT_W-1:0] ws;
         logic [OFF_W-1:0] wo;
         if (want_stat.size() == 0) begin
            report($sformatf("unexpected result status=%0d offset=%0d", st, off));
            return;
         end
         ws = want_stat.pop_front();
         wo = want_off.pop_front();
         if (st !== ws)
            report($sformatf("status %0d, wanted %0d", st, ws));
         if (off !== wo)
            report($sformatf("offset %0d, wanted %0d", off, wo));
      endtask

      function int pending();
         return want_stat.size();
      endfunction
   endclass

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation;
   logic [SIZE_W-1:0]   req_request_size;
   logic [OFF_W-1:0]    req_block_offset;
   logic                rsp_valid;
   logic                rsp_stall;
   logic [STAT_W-1:0]   rsp_status;
   logic [OFF_W-1:0]    rsp_result_offset;

   heap_tracker tracker;
   int live_offs[$];
   bit burst_mode;

   buddy_block_allocator_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_operation(req_operation), .req_request_size(req_request_size),
      .req_block_offset(req_block_offset),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_status(rsp_status), .rsp_result_offset(rsp_result_offset)
   );

   // clock
   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // overall time limit
   initial begin
      #100ms;
      $display("timeout waiting for results");
      $display("Test completed with failures");
      $finish;
   end

   // result side: random stall, mostly short bursts, a few long ones
   initial begin
      int left;
      rsp_stall = 1'b0;
      left = 0;
      forever begin
         @(posedge clock);
         if (left > 0) begin
            left--;
         end else if (!burst_mode && $urandom_range(0, 99) < 20) begin
            left = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 120)
                                                : $urandom_range(1, 3);
         end
         rsp_stall <= (left > 0);
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(rsp_status, rsp_result_offset);
   end

   // drive one item, hold it until accepted, then note it
   task send_item(logic [OP_W-1:0] op, int size, int off);
      logic [STAT_W-1:0] st;
      int got, gap;
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_request_size <= size[SIZE_W-1:0];
      req_block_offset <= off[OFF_W-1:0];
      do @(posedge clock); while (req_stall);
      tracker.note_request(op, size[SIZE_W-1:0], off[OFF_W-1:0], st, got);
      // keep the live-block list in step with the tree
      if (op == OP_ALLOC && st == STAT_OK) live_offs.push_back(got);
      if (op == OP_FREE && st == STAT_OK) drop_live(off[OFF_W-1:0]);
      if (op == OP_REALLOC) begin
         if (st != STAT_NOTFOUND || got != 0 || st == STAT_OK) drop_live(off[OFF_W-1:0]);
         if (st != STAT_NOSPACE) live_offs.push_back(got);
      end
      // gap before the next item
      gap = 0;
      if (!burst_mode && $urandom_range(0, 99) < 40)
         gap = ($urandom_range(0, 14) == 0) ? $urandom_range(15, 100) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task drop_live(int off);
      foreach (live_offs[i])
         if (live_offs[i] == off) begin
            live_offs.delete(i);
            return;
         end
   endtask

   // stop sending until every owed result has come back
   task drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (tracker.pending() != 0) @(posedge clock);
   endtask

   function int pick_size();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return $urandom_range(0, 64 << $urandom_range(0, 6));
      if (r < 97) return $urandom_range(0, HEAP);
      return $urandom_range(HEAP + 1, (1 << SIZE_W) - 1);
   endfunction

   initial begin
      int r, k, off;
      tracker = new();
      burst_mode = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_operation = OP_ALLOC;
      req_request_size = '0;
      req_block_offset = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes and special cases
      send_item(OP_ALLOC, 0, 0);              // zero size gets one leaf
      send_item(OP_ALLOC, HEAP, 0);           // root not empty
      send_item(OP_FREE, 0, 0);
      send_item(OP_FREE, 0, 0);               // already free
      send_item(OP_ALLOC, HEAP, 0);           // whole heap
      send_item(OP_ALLOC, 1, 0);              // no space
      send_item(OP_REALLOC, 64, 0);           // realloc success
      send_item(OP_ALLOC, HEAP + 1, 0);       // too large
      send_item(OP_ALLOC, (1 << SIZE_W) - 1, 65535);
      send_item(OP_UNUSED, 100, 128);         // unknown operation
      send_item(OP_FREE, 0, 64);              // offset inside a leaf
      send_item(OP_FREE, 0, 65535);           // offset at the far end
      send_item(OP_ALLOC, 65, 0);
      send_item(OP_ALLOC, 128, 0);
      send_item(OP_ALLOC, 129, 0);
      send_item(OP_FREE, 0, 256);             // frees the block taken for size 128
      send_item(OP_REALLOC, 32768, 4097);     // realloc with a missed free
      send_item(OP_REALLOC, HEAP, 0);         // realloc that cannot fit
      send_item(OP_FREE, 0, 32768);
      send_item(OP_FREE, 0, 0);
      send_item(OP_FREE, 0, 128);
      send_item(OP_FREE, 0, 256);
      send_item(OP_FREE, 0, 512);
      drain();

      // random: mostly alloc/free pairs on live blocks, some noise
      for (k = 0; k < 800; k++) begin
         if (k % 100 == 0) burst_mode = $urandom_range(0, 2) == 0;
         if (k == 400) drain();
         r = $urandom_range(0, 99);
         if (live_offs.size() > 30 && r < 45) r += 45;
         off = live_offs.size() ? live_offs[$urandom_range(0, live_offs.size() - 1)] : 0;
         if (live_offs.size() == 0 || r < 45)
            send_item(OP_ALLOC, pick_size(), $urandom_range(0, 65535));
         else if (r < 80)
            send_item(OP_FREE, $urandom_range(0, (1 << SIZE_W) - 1), off);
         else if (r < 90)
            send_item(OP_REALLOC, pick_size(), off);
         else if (r < 94)
            send_item(OP_FREE, 0, $urandom_range(0, 65535));
         else if (r < 96)
            send_item(OP_FREE, 0, $urandom_range(0, 511) << 7);
         else if (r < 99)
            send_item(OP_REALLOC, pick_size(), $urandom_range(0, 65535));
         else
            send_item(OP_UNUSED, $urandom_range(0, (1 << SIZE_W) - 1),
                      $urandom_range(0, 65535));
      end

      // wrap up
      drain();
      repeat (50) @(posedge clock);
      $display("covered %0d grants, %0d frees, %0d missed frees, %0d refused requests",
               tracker.n_grant, tracker.n_freed, tracker.n_miss, tracker.n_full);
      if (tracker.errors == 0 && tracker.pending() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end
endmodule
